>>> design/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared widths, payload types and state codes of the bid/ask OHLC bar
// aggregator.
// ----------------------------------------------------------------------------
package ohlc_pkg;

    // Field widths of the quote stream and of the emitted bars.
    localparam int TIME_W   = 40;
    localparam int PRICE_W  = 32;
    localparam int PERIOD_W = 17;
    localparam int COUNT_W  = 32;

    // Width of the bit counter of the remainder divider.
    localparam int DIV_CNT_W = $clog2(TIME_W);

    // Bar period after reset, in seconds.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(600);

    // Request operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Input request: one quote tick or a flush.
    typedef struct packed {
        logic               opcode;
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] bid_price;
        logic [PRICE_W-1:0] ask_price;
    } in_item_t;

    // Result request: one finished bar.
    typedef struct packed {
        logic [TIME_W-1:0]  bar_start;
        logic [PRICE_W-1:0] bid_first;
        logic [PRICE_W-1:0] bid_peak;
        logic [PRICE_W-1:0] bid_low;
        logic [PRICE_W-1:0] bid_last;
        logic [PRICE_W-1:0] ask_first;
        logic [PRICE_W-1:0] ask_peak;
        logic [PRICE_W-1:0] ask_low;
        logic [PRICE_W-1:0] ask_last;
        logic [COUNT_W-1:0] tick_count;
    } out_bar_t;

    // Classified job handed from the front end to the bar engine.
    typedef struct packed {
        logic               is_flush;
        logic [TIME_W-1:0]  bucket;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
    } job_t;

    // Front end states.
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

endpackage

>>> design/ohlc_front.sv
// ----------------------------------------------------------------------------
// ohlc_front
// Accepts requests, computes the bucket start of each tick with a bit-serial
// remainder divider and hands classified jobs to the queue.
// ----------------------------------------------------------------------------
module ohlc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ohlc_pkg::PERIOD_W-1:0]     bar_period,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ohlc_pkg::in_item_t                s_item,
    output logic                              job_valid,
    input  logic                              job_ready,
    output ohlc_pkg::job_t                    job
);

    ohlc_pkg::front_state_t                   state_reg, state_next;
    ohlc_pkg::in_item_t                       item_reg;
    logic [ohlc_pkg::TIME_W-1:0]              shift_reg, shift_next;
    logic [ohlc_pkg::PERIOD_W-1:0]            rem_reg, rem_next;
    logic [ohlc_pkg::PERIOD_W-1:0]            period_reg;
    logic [ohlc_pkg::DIV_CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ohlc_pkg::PERIOD_W:0]              shifted;
    logic [ohlc_pkg::PERIOD_W:0]              period_ext;
    logic [ohlc_pkg::PERIOD_W:0]              diff;
    logic                                     accept;

    assign accept = s_valid && s_ready;

    // One remainder step: bring in the next timestamp bit, subtract if it fits.
    assign shifted    = {rem_reg, shift_reg[ohlc_pkg::TIME_W-1]};
    assign period_ext = {1'b0, period_reg};
    assign diff       = shifted - period_ext;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ohlc_pkg::FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers; a zero period counts as one second.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg   <= s_item;
            period_reg <= (bar_period == '0) ? ohlc_pkg::PERIOD_W'(1) : bar_period;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

    // Next state and outputs.
    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            ohlc_pkg::FR_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    shift_next = s_item.tick_time;
                    rem_next   = '0;
                    cnt_next   = ohlc_pkg::DIV_CNT_W'(ohlc_pkg::TIME_W - 1);
                    if (s_item.opcode == ohlc_pkg::OP_FLUSH) begin
                        state_next = ohlc_pkg::FR_PUSH;
                    end else begin
                        state_next = ohlc_pkg::FR_DIV;
                    end
                end
            end
            ohlc_pkg::FR_DIV: begin
                shift_next = {shift_reg[ohlc_pkg::TIME_W-2:0], 1'b0};
                if (shifted >= period_ext) begin
                    rem_next = diff[ohlc_pkg::PERIOD_W-1:0];
                end else begin
                    rem_next = shifted[ohlc_pkg::PERIOD_W-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ohlc_pkg::FR_PUSH;
                end
            end
            ohlc_pkg::FR_PUSH: begin
                job_valid = 1'b1;
                if (job_ready) begin
                    state_next = ohlc_pkg::FR_IDLE;
                end
            end
            default: begin
                state_next = ohlc_pkg::FR_IDLE;
            end
        endcase
    end

    // The bucket start is the timestamp less its remainder by the period.
    always_comb begin
        job.is_flush = (item_reg.opcode == ohlc_pkg::OP_FLUSH);
        job.bucket   = item_reg.tick_time
                       - {{(ohlc_pkg::TIME_W - ohlc_pkg::PERIOD_W){1'b0}}, rem_reg};
        job.bid      = item_reg.bid_price;
        job.ask      = item_reg.ask_price;
    end

endmodule

>>> design/ohlc_fifo.sv
// ----------------------------------------------------------------------------
// ohlc_fifo
// Short queue of classified jobs between the front end and the bar engine.
// ----------------------------------------------------------------------------
module ohlc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  ohlc_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ohlc_pkg::job_t  pop_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ohlc_pkg::job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> design/ohlc_back.sv
// ----------------------------------------------------------------------------
// ohlc_back
// Bar engine: keeps the open bar, closes it on a bucket change or flush and
// holds the finished bar in the output register.
// ----------------------------------------------------------------------------
module ohlc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  ohlc_pkg::job_t      job,
    output logic                m_valid,
    input  logic                m_ready,
    output ohlc_pkg::out_bar_t  m_bar
);

    logic                       open_reg;
    ohlc_pkg::out_bar_t         bar_reg;
    ohlc_pkg::out_bar_t         out_reg;
    logic                       out_valid_reg;
    logic                       take;
    logic                       emit;
    logic                       start;

    // A job is taken only when the output register can hold a result.
    assign job_ready = !out_valid_reg || m_ready;
    assign take      = job_valid && job_ready;
    assign emit      = take && open_reg && (job.is_flush || (job.bucket != bar_reg.bar_start));
    assign start     = take && !job.is_flush && (!open_reg || (job.bucket != bar_reg.bar_start));

    assign m_valid = out_valid_reg;
    assign m_bar   = out_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                open_reg <= !job.is_flush;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Finished bar goes to the output register.
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= bar_reg;
        end
    end

    // Open a new bar or extend the current one.
    always_ff @(posedge aclk) begin
        if (start) begin
            bar_reg.bar_start  <= job.bucket;
            bar_reg.bid_first  <= job.bid;
            bar_reg.bid_peak   <= job.bid;
            bar_reg.bid_low    <= job.bid;
            bar_reg.bid_last   <= job.bid;
            bar_reg.ask_first  <= job.ask;
            bar_reg.ask_peak   <= job.ask;
            bar_reg.ask_low    <= job.ask;
            bar_reg.ask_last   <= job.ask;
            bar_reg.tick_count <= ohlc_pkg::COUNT_W'(1);
        end else if (take && !job.is_flush) begin
            if (job.bid > bar_reg.bid_peak) begin
                bar_reg.bid_peak <= job.bid;
            end
            if (job.bid < bar_reg.bid_low) begin
                bar_reg.bid_low <= job.bid;
            end
            bar_reg.bid_last <= job.bid;
            if (job.ask > bar_reg.ask_peak) begin
                bar_reg.ask_peak <= job.ask;
            end
            if (job.ask < bar_reg.ask_low) begin
                bar_reg.ask_low <= job.ask;
            end
            bar_reg.ask_last <= job.ask;
            if (bar_reg.tick_count != '1) begin
                bar_reg.tick_count <= bar_reg.tick_count + 1'b1;
            end
        end
    end

endmodule

>>> design/bid_ask_ohlc_bar_aggregator.sv
// ----------------------------------------------------------------------------
// bid_ask_ohlc_bar_aggregator
// Groups quote ticks into fixed time buckets and emits bid and ask OHLC bars.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one request per handshake: a quote tick (opcode tick)
// or a flush. The m_ channel delivers one finished bar per handshake. The
// cfg_ channel writes the bar period in seconds (zero acts as one second);
// write it only while no request is in flight.
// A tick holds the front end while it is accepted, while the serial remainder
// divider works through the timestamp one bit per cycle, and until the job
// enters the job queue, which stalls while the queue is full. A flush skips
// the divider. The front end takes no new request until the last one is queued.
// A bar closed by a tick or a flush appears on m_valid once that request has
// passed the queue and the bar engine has loaded the output register. The
// first tick only opens a bar and a flush with no open bar gives no result.
// When the receiver stalls, the bar waits in the output register; the queue
// of QUEUE_DEPTH jobs keeps the front end taking requests until it fills.
// Synchronous reset closes any open bar, empties the queue and sets the
// period to 600 seconds.
// ----------------------------------------------------------------------------
module bid_ask_ohlc_bar_aggregator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ohlc_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ohlc_pkg::out_bar_t                m_bar,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ohlc_pkg::PERIOD_W-1:0]     cfg_data
);

    logic [ohlc_pkg::PERIOD_W-1:0]            period_reg;
    logic                                     fj_valid;
    logic                                     fj_ready;
    ohlc_pkg::job_t                           fj_job;
    logic                                     bj_valid;
    logic                                     bj_ready;
    ohlc_pkg::job_t                           bj_job;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= ohlc_pkg::PERIOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            period_reg <= cfg_data;
        end
    end

    // Front end: accept and compute buckets.
    ohlc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bar_period (period_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .job_valid  (fj_valid),
        .job_ready  (fj_ready),
        .job        (fj_job)
    );

    // Job queue.
    ohlc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_job   (fj_job),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_job    (bj_job)
    );

    // Bar engine.
    ohlc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_bar     (m_bar)
    );

    // An emitted bar always holds at least one tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bar.tick_count != '0))
        else $error("emitted bar with zero ticks");

    // The bid extremes bracket the first and last bid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bar.bid_low <= m_bar.bid_first && m_bar.bid_first <= m_bar.bid_peak
                     && m_bar.bid_low <= m_bar.bid_last && m_bar.bid_last <= m_bar.bid_peak))
        else $error("bid first or last outside bid low and peak");

    // The ask extremes bracket the first and last ask.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bar.ask_low <= m_bar.ask_first && m_bar.ask_first <= m_bar.ask_peak
                     && m_bar.ask_low <= m_bar.ask_last && m_bar.ask_last <= m_bar.ask_peak))
        else $error("ask first or last outside ask low and peak");

endmodule
